/* rtl/rppt_pkg.sv */
// Shared constants, types and helpers for the ROI polygon point test.
`default_nettype none

package rppt_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int COORD_BITS   = 16;
  localparam int MIN_VERTICES = 3;

  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int OPND_W = COORD_BITS + 2;
  localparam int PROD_W = 2 * OPND_W;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [OPND_W-1:0]     opnd_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_QUERY = 2'd2
  } mode_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vtx_t;

  typedef struct packed {
    logic we;
    idx_t addr;
    vtx_t data;
  } wr_req_t;

  typedef struct packed {
    logic en;
    idx_t addr;
  } rd_req_t;

  // Coordinate at doubled scale, sign-extended to operand width.
  function automatic opnd_t dbl(input coord_t v);
    return {v[COORD_BITS-1], v, 1'b0};
  endfunction

  // Coordinate sign-extended to operand width.
  function automatic opnd_t sext(input coord_t v);
    return {v[COORD_BITS-1], v[COORD_BITS-1], v};
  endfunction

endpackage

`default_nettype wire

/* rtl/rppt_in_if.sv */
// Input item channel: mode, vertex and bounding box fields.
`default_nettype none

interface rppt_in_if import rppt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            mode;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic signed [COORD_BITS-1:0] box_top;
  logic signed [COORD_BITS-1:0] box_left;
  logic signed [COORD_BITS-1:0] box_bottom;
  logic signed [COORD_BITS-1:0] box_right;

  modport source (
    output valid, mode, vertex_x, vertex_y, box_top, box_left, box_bottom, box_right,
    input  ready
  );

  modport sink (
    input  valid, mode, vertex_x, vertex_y, box_top, box_left, box_bottom, box_right,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/rppt_out_if.sv */
// Result item channel: accepted flag, inside flag and vertex count.
`default_nettype none

interface rppt_out_if import rppt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             accepted;
  logic             inside_res;
  logic [CNT_W-1:0] vertex_total;

  modport source (
    output valid, accepted, inside_res, vertex_total,
    input  ready
  );

  modport sink (
    input  valid, accepted, inside_res, vertex_total,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/rppt_store.sv */
// Vertex store: one write port, one registered read port.
`default_nettype none

module rppt_store import rppt_pkg::*; (
  input  wire logic    clk,
  input  wire wr_req_t wr_req,
  input  wire rd_req_t rd_req,
  output vtx_t         rd_data_r
);

  vtx_t mem [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (wr_req.we) begin
      mem[wr_req.addr] <= wr_req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      rd_data_r <= mem[rd_req.addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/rppt_mul.sv */
// Shared signed multiplier with a registered product.
`default_nettype none

module rppt_mul import rppt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  en,
  input  wire opnd_t op_a,
  input  wire opnd_t op_b,
  output prod_t      prod_r
);

  prod_t prod_nxt;

  assign prod_nxt = prod_t'(op_a) * prod_t'(op_b);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/roi_polygon_point_test_top.sv */
// Region-of-interest polygon store with a ray-casting point-in-polygon query.
//
// Usage:
//   in_ch carries one item per valid/ready handshake. Mode clear empties the
//   polygon, mode add appends a vertex (refused when the store holds
//   MAX_VERTICES), mode query tests the center of a bounding box against the
//   polygon. Every item gives exactly one result on out_ch: accepted,
//   inside_res and the vertex count after the item.
//   Clear, add and an unused mode go from idle straight to the final step,
//   which loads the result register. A query over n >= 3 vertices reads the
//   last vertex first, then walks every edge; fewer than three skip the walk.
//   Each edge takes one store read, then two passes through the
//   single shared multiplier and a compare of the two products.
//   One item is in work at a time; in_ch.ready is high only while idle, so
//   a new item is taken only after the previous one has left its final step.
//   When out_ch.ready is low the result stays registered and the block holds
//   in its final step until the slot frees; a new item may be taken while a
//   previous result still waits.
//   Reset (rst_n low, synchronous) empties the polygon, drops any pending
//   result and returns to idle. Store contents are not cleared.
`default_nettype none

module roi_polygon_point_test_top import rppt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  rppt_in_if.sink   in_ch,
  rppt_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREV,
    S_OP,
    S_M1,
    S_M2,
    S_CMP,
    S_DONE
  } state_t;

  state_t  state_r;
  cnt_t    cnt_r;
  idx_t    idx_r;
  opnd_t   cx2_r, cy2_r;
  coord_t  prev_x_r, prev_y_r;
  opnd_t   op1a_r, op1b_r, op2a_r, op2b_r;
  logic    straddle_r;
  prod_t   p1_r;
  logic    acc_r, inside_r;
  logic    out_valid_r, out_acc_r, out_ins_r;
  cnt_t    out_tot_r;

  logic    in_fire;
  logic    full;
  cnt_t    cnt_m1;
  wr_req_t wr_req;
  rd_req_t rd_req;
  vtx_t    rd_data;
  logic    mul_en;
  opnd_t   mul_a, mul_b;
  prod_t   prod;

  // Edge operands from the previous vertex (j) and the one just read (i).
  opnd_t   xi, yi, xj, yj, dy, lhs_a, rhs_a, rhs_b;
  logic    straddle;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign full        = (cnt_r >= cnt_t'(MAX_VERTICES));
  assign cnt_m1      = cnt_r - cnt_t'(1);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.accepted     = out_acc_r;
  assign out_ch.inside_res   = out_ins_r;
  assign out_ch.vertex_total = out_tot_r;

  always_comb begin
    wr_req.we     = in_fire && (in_ch.mode == MODE_ADD) && !full;
    wr_req.addr   = cnt_r[IDX_W-1:0];
    wr_req.data.x = in_ch.vertex_x;
    wr_req.data.y = in_ch.vertex_y;
  end

  always_comb begin
    rd_req.en   = 1'b0;
    rd_req.addr = idx_r + idx_t'(1);
    unique case (state_r)
      S_IDLE: begin
        rd_req.en   = in_fire && (in_ch.mode == MODE_QUERY);
        rd_req.addr = cnt_m1[IDX_W-1:0];
      end
      S_PREV: begin
        rd_req.en   = 1'b1;
        rd_req.addr = '0;
      end
      S_M2: begin
        rd_req.en = 1'b1;
      end
      default: begin
        rd_req.en = 1'b0;
      end
    endcase
  end

  always_comb begin
    xi       = dbl(rd_data.x);
    yi       = dbl(rd_data.y);
    xj       = dbl(prev_x_r);
    yj       = dbl(prev_y_r);
    dy       = yj - yi;
    lhs_a    = cx2_r - xi;
    rhs_a    = xj - xi;
    rhs_b    = cy2_r - yi;
    straddle = (yi > cy2_r) != (yj > cy2_r);
  end

  assign mul_en = (state_r == S_M1) || (state_r == S_M2);
  assign mul_a  = (state_r == S_M1) ? op1a_r : op2a_r;
  assign mul_b  = (state_r == S_M1) ? op1b_r : op2b_r;

  rppt_store u_store (
    .clk      (clk),
    .wr_req   (wr_req),
    .rd_req   (rd_req),
    .rd_data_r(rd_data)
  );

  rppt_mul u_mul (
    .clk   (clk),
    .en    (mul_en),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .prod_r(prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      acc_r       <= 1'b0;
      inside_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_acc_r   <= 1'b0;
      out_ins_r   <= 1'b0;
      out_tot_r   <= '0;
    end else begin
      // The final step reloads the result register itself.
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            inside_r <= 1'b0;
            unique case (in_ch.mode)
              MODE_CLEAR: begin
                cnt_r   <= '0;
                acc_r   <= 1'b1;
                state_r <= S_DONE;
              end
              MODE_ADD: begin
                acc_r   <= !full;
                state_r <= S_DONE;
                if (!full) begin
                  cnt_r <= cnt_r + cnt_t'(1);
                end
              end
              MODE_QUERY: begin
                acc_r <= 1'b1;
                cx2_r <= sext(in_ch.box_left) + sext(in_ch.box_right);
                cy2_r <= sext(in_ch.box_top) + sext(in_ch.box_bottom);
                idx_r <= '0;
                if (cnt_r >= cnt_t'(MIN_VERTICES)) begin
                  state_r <= S_PREV;
                end else begin
                  state_r <= S_DONE;
                end
              end
              default: begin
                acc_r   <= 1'b0;
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_PREV: begin
          prev_x_r <= rd_data.x;
          prev_y_r <= rd_data.y;
          state_r  <= S_OP;
        end
        S_OP: begin
          // Order the products so the compare follows the sign of dy.
          if (dy > opnd_t'(0)) begin
            op1a_r <= lhs_a;
            op1b_r <= dy;
            op2a_r <= rhs_a;
            op2b_r <= rhs_b;
          end else begin
            op1a_r <= rhs_a;
            op1b_r <= rhs_b;
            op2a_r <= lhs_a;
            op2b_r <= dy;
          end
          straddle_r <= straddle;
          prev_x_r   <= rd_data.x;
          prev_y_r   <= rd_data.y;
          state_r    <= S_M1;
        end
        S_M1: begin
          state_r <= S_M2;
        end
        S_M2: begin
          p1_r    <= prod;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (straddle_r && (p1_r < prod)) begin
            inside_r <= !inside_r;
          end
          if (idx_r == cnt_m1[IDX_W-1:0]) begin
            state_r <= S_DONE;
          end else begin
            idx_r   <= idx_r + idx_t'(1);
            state_r <= S_OP;
          end
        end
        S_DONE: begin
          // Hold until the result register is free.
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_acc_r   <= acc_r;
            out_ins_r   <= inside_r;
            out_tot_r   <= cnt_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/rppt_check.sv */
// Port-level checks for the ROI polygon point test, bound to the top level.
`default_nettype none

module rppt_check import rppt_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic             out_accepted,
  input wire logic             out_inside_res,
  input wire logic [CNT_W-1:0] out_vertex_total
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_accepted) &&
      $stable(out_inside_res) && $stable(out_vertex_total))
    else $error("result changed while stalled");

  // One item at a time: busy right after an accept.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // Only a carried-out query can report inside.
  a_inside_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inside_res |-> out_accepted)
    else $error("inside reported for a refused item");

  // The count stays within MAX_VERTICES; an inside answer needs at least three vertices.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_vertex_total <= CNT_W'(MAX_VERTICES)) &&
      (!out_inside_res || (out_vertex_total >= CNT_W'(MIN_VERTICES))))
    else $error("vertex count out of range");

endmodule

bind roi_polygon_point_test_top rppt_check u_rppt_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_accepted    (out_ch.accepted),
  .out_inside_res  (out_ch.inside_res),
  .out_vertex_total(out_ch.vertex_total)
);

`default_nettype wire
